// ----- rtl/core/ncc_pkg.sv -----
// Package for the nearest-centroid classifier: word types, cell control
// struct, cell operation codes, controller states and register indexes.
// No dependencies.
`default_nettype none
package ncc_pkg;

  localparam int ELEM_W = 13;
  localparam int DIST_W = 64;

  // Register indexes on the configuration port
  localparam logic REG_VECTOR_LENGTH     = 1'b0;
  localparam logic REG_RECORDS_PER_CLASS = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         class_label;
    logic [12:0]        element_index;
    logic signed [15:0] sample_value;
  } ncc_in_t;

  typedef struct packed {
    logic [2:0]  best_class;
    logic [62:0] near_dist;
    logic        label_matches;
  } ncc_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_READ,
    OP_TRAIN,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_ABS,
    OP_MUL,
    OP_ACC
  } ncc_op_t;

  typedef struct packed {
    ncc_op_t            op;
    logic [2:0]         label;
    logic [ELEM_W-1:0]  addr;
    logic signed [15:0] x;
    logic [15:0]        divisor;
    logic               acc_clr;
  } ncc_ctrl_t;

  // Running nearest candidate handed down the cell row
  typedef struct packed {
    logic [2:0]        cls;
    logic [DIST_W-1:0] dsq;
  } ncc_cand_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TRD,
    S_TWR,
    S_CRD,
    S_CLOAD,
    S_DIV,
    S_ABS,
    S_MUL,
    S_ACC,
    S_SCAN,
    S_OUT
  } ncc_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/nearest_centroid_classify.sv -----
// A classify word runs the 32-step divider in each class cell; the last
// element adds a scan of the row of NUM_CLASSES cells.
// One word at a time; dropped words are accepted and discarded.
// Reset: synchronous, clears control and distances, loads register defaults,
// then a clearing pass zeroes every class sum while no word is accepted.
// Depends on ncc_pkg and ncc_cell.
`default_nettype none
module nearest_centroid_classify #(
  parameter int NUM_CLASSES = 5,
  parameter int MAX_DIM     = 8192
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire              cfg_index,
  input  wire [15:0]       cfg_wdata,
  input  wire              in_valid,
  output logic             in_ready,
  input  ncc_pkg::ncc_in_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output ncc_pkg::ncc_out_t out_data
);
  import ncc_pkg::*;

  localparam int AW = $clog2(MAX_DIM);
  localparam int CW = (AW > 6) ? AW : 6;

  ncc_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  ncc_in_t    item_r;
  logic [13:0] vlen_r;
  logic [15:0] rpc_r;
  logic [2:0]  exp_label_r;
  logic        out_valid_r, out_valid_nxt;
  ncc_out_t    out_data_r;
  ncc_out_t    res;

  logic [13:0] len;
  logic        drop;
  logic        last;
  ncc_ctrl_t   ctrl;
  ncc_cand_t   chain [NUM_CLASSES+1];

  // Effective vector length and word screening
  always_comb begin
    if (vlen_r == 14'd0) len = 14'd1;
    else if (vlen_r > 14'(MAX_DIM)) len = 14'(MAX_DIM);
    else len = vlen_r;
    drop = ({1'b0, in_data.element_index} >= len) ||
           (!in_data.req_type && (32'(in_data.class_label) >= 32'(NUM_CLASSES)));
    last = ({1'b0, item_r.element_index} == (len - 14'd1));
  end

  // Next state, counter and cell control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    in_ready      = (state_r == S_IDLE);
    ctrl.op       = OP_NONE;
    ctrl.label    = item_r.class_label;
    ctrl.addr     = item_r.element_index;
    ctrl.x        = item_r.sample_value;
    ctrl.divisor  = (rpc_r == 16'd0) ? 16'd1 : rpc_r;
    ctrl.acc_clr  = (item_r.element_index == '0);
    res.best_class    = chain[NUM_CLASSES].cls;
    res.near_dist     = chain[NUM_CLASSES].dsq[62:0];
    res.label_matches = (chain[NUM_CLASSES].cls == exp_label_r);
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ctrl.op   = OP_CLEAR;
        ctrl.addr = ELEM_W'(cnt_r[AW-1:0]);
        if (cnt_r == CW'(MAX_DIM - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid && !drop) begin
          state_nxt = in_data.req_type ? S_CRD : S_TRD;
        end
      end
      S_TRD: begin
        ctrl.op   = OP_READ;
        state_nxt = S_TWR;
      end
      S_TWR: begin
        ctrl.op   = OP_TRAIN;
        state_nxt = S_IDLE;
      end
      S_CRD: begin
        ctrl.op   = OP_READ;
        state_nxt = S_CLOAD;
      end
      S_CLOAD: begin
        ctrl.op   = OP_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctrl.op = OP_DIV_STEP;
        if (cnt_r == CW'(31)) begin
          cnt_nxt   = '0;
          state_nxt = S_ABS;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ABS: begin
        ctrl.op   = OP_ABS;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        ctrl.op   = OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        ctrl.op   = OP_ACC;
        cnt_nxt   = '0;
        state_nxt = last ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (cnt_r == CW'(NUM_CLASSES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        // Load the result once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      vlen_r      <= 14'd1536;
      rpc_r       <= 16'd200;
      exp_label_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VECTOR_LENGTH:     vlen_r <= cfg_wdata[13:0];
          REG_RECORDS_PER_CLASS: rpc_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (state_r == S_ACC && item_r.element_index == '0) begin
        exp_label_r <= item_r.class_label;
      end
    end
  end

  // Hold the accepted word and the result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    if (state_r == S_OUT && (!out_valid_r || out_ready)) out_data_r <= res;
  end

  // Row of class cells; the nearest candidate moves one cell per cycle
  assign chain[0].cls = '0;
  assign chain[0].dsq = '1;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
    ncc_cell #(
      .MAX_DIM  (MAX_DIM),
      .CLASS_ID (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cand_in  (chain[g]),
      .cand_out (chain[g+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLEAR && !in_ready))
    else $error("reset did not start the clearing pass");
  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside the scan end");
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_data_r.best_class) < 32'(NUM_CLASSES)))
    else $error("best class out of range");

endmodule
`default_nettype wire

// ----- rtl/core/ncc_cell.sv -----
// One class cell: sum memory for its class, serial divider, squared
// difference, distance accumulator and one stage of the nearest-class row.
// Depends on ncc_pkg.
`default_nettype none
module ncc_cell #(
  parameter int MAX_DIM  = 8192,
  parameter int CLASS_ID = 0
) (
  input  wire                clk,
  input  wire                rst_n,
  input  ncc_pkg::ncc_ctrl_t ctrl,
  input  ncc_pkg::ncc_cand_t cand_in,
  output ncc_pkg::ncc_cand_t cand_out
);
  import ncc_pkg::*;

  localparam int AW = $clog2(MAX_DIM);

  logic signed [31:0] mem [MAX_DIM];
  logic signed [31:0] rdata_r;
  logic [15:0]        rem_r;
  logic [31:0]        quo_r;
  logic               neg_r;
  logic [31:0]        ad_r;
  logic [63:0]        sq_r;
  logic [62:0]        dist_r;
  ncc_cand_t          cand_r;

  logic signed [32:0] tsum;
  logic signed [31:0] sat_sum;
  logic               hit;
  logic [31:0]        mag;
  logic [16:0]        trial;
  logic [17:0]        diff;
  logic signed [33:0] mean;
  logic signed [33:0] dlt;
  logic signed [33:0] ndlt;
  logic [62:0]        base;
  logic [64:0]        tot;

  // Saturating training add, divider step, difference and distance sum
  always_comb begin
    tsum = 33'(rdata_r) + 33'(ctrl.x);
    if (tsum[32] != tsum[31]) begin
      sat_sum = tsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_sum = tsum[31:0];
    end
    hit   = (ctrl.label == 3'(CLASS_ID));
    mag   = rdata_r[31] ? (32'd0 - rdata_r) : rdata_r;
    trial = {rem_r, quo_r[31]};
    diff  = {1'b0, trial} - {2'b00, ctrl.divisor};
    mean  = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
    dlt   = 34'(ctrl.x) - mean;
    ndlt  = -dlt;
    base  = ctrl.acc_clr ? 63'd0 : dist_r;
    tot   = {2'b00, base} + {1'b0, sq_r};
  end

  // Memory and datapath stages
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_CLEAR: mem[ctrl.addr[AW-1:0]] <= '0;
      OP_READ:  rdata_r <= mem[ctrl.addr[AW-1:0]];
      OP_TRAIN: begin
        if (hit) mem[ctrl.addr[AW-1:0]] <= sat_sum;
      end
      OP_DIV_LOAD: begin
        quo_r <= mag;
        rem_r <= '0;
        neg_r <= rdata_r[31];
      end
      OP_DIV_STEP: begin
        if (!diff[17]) begin
          rem_r <= diff[15:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= trial[15:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end
      OP_ABS: ad_r <= dlt[33] ? ndlt[31:0] : dlt[31:0];
      OP_MUL: sq_r <= ad_r * ad_r;
      default: begin
      end
    endcase
  end

  // Distance accumulator and nearest-candidate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
      cand_r <= '0;
    end else begin
      if (ctrl.op == OP_ACC) begin
        dist_r <= (tot > {2'b00, {63{1'b1}}}) ? {63{1'b1}} : tot[62:0];
      end
      if ({1'b0, dist_r} < cand_in.dsq) begin
        cand_r.cls <= 3'(CLASS_ID);
        cand_r.dsq <= {1'b0, dist_r};
      end else begin
        cand_r <= cand_in;
      end
    end
  end

  assign cand_out = cand_r;

endmodule
`default_nettype wire

// ----- verif/tb_nearest_centroid_classify.sv -----
// Testbench for nearest_centroid_classify: random valid/ready traffic of
// training and classify words, checked against an in-bench centroid predictor.
// Depends on ncc_pkg and the classifier RTL.
`default_nettype none
module tb_nearest_centroid_classify;
  import ncc_pkg::*;

  localparam int NCLS = 5;
  localparam int MAXD = 8192;
  localparam logic [63:0] DIST_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_VECTOR_LENGTH;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  ncc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ncc_out_t out_data;

  nearest_centroid_classify #(.NUM_CLASSES(NCLS), .MAX_DIM(MAXD)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic signed [31:0] class_sum [NCLS*MAXD];
  logic [63:0] class_dist [NCLS];
  logic [2:0] want_label;
  logic [13:0] vec_len;
  logic [15:0] rec_div;

  ncc_in_t word_q [$];
  ncc_out_t result_q [$];
  int errors = 0;

  function automatic int eff_len();
    int n;
    n = vec_len;
    if (n == 0) n = 1;
    if (n > MAXD) n = MAXD;
    return n;
  endfunction

  // Apply one accepted word to the predictor; queue a result on last element
  task automatic classify_word(input ncc_in_t w);
    int len;
    longint s, dv, mean, d;
    logic [63:0] sq, cur, bd;
    int best, ci;
    ncc_out_t r;
    len = eff_len();
    if (w.element_index >= len) return;
    if (!w.req_type) begin
      if (w.class_label >= NCLS) return;
      s = longint'(class_sum[w.class_label*MAXD + w.element_index]) + longint'(w.sample_value);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      class_sum[w.class_label*MAXD + w.element_index] = s[31:0];
      return;
    end
    if (w.element_index == 0) begin
      for (ci = 0; ci < NCLS; ci++) class_dist[ci] = '0;
      want_label = w.class_label;
    end
    dv = (rec_div == 0) ? 1 : longint'(rec_div);
    for (ci = 0; ci < NCLS; ci++) begin
      mean = longint'(class_sum[ci*MAXD + w.element_index]) / dv;
      d = longint'(w.sample_value) - mean;
      if (d < 0) d = -d;
      sq = d * d;
      cur = class_dist[ci];
      if (cur > DIST_SAT) cur = DIST_SAT;
      if (sq > DIST_SAT - cur) cur = DIST_SAT;
      else cur = cur + sq;
      class_dist[ci] = cur;
    end
    if (w.element_index == len - 1) begin
      best = 0;
      bd = class_dist[0];
      for (ci = 1; ci < NCLS; ci++)
        if (class_dist[ci] < bd) begin
          bd = class_dist[ci];
          best = ci;
        end
      r.best_class = best[2:0];
      r.near_dist = bd[62:0];
      r.label_matches = (best == want_label);
      result_q.push_back(r);
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Driver: hold each word until accepted, then advance
  int in_gap = 0;
  bit hold_off = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) classify_word(in_data);
      if (in_valid && !in_ready) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (!hold_off && word_q.size() > 0) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and compare against oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_data);
        end else begin
          ncc_out_t e;
          e = result_q.pop_front();
          if (e !== out_data) begin
            errors++;
            if (errors <= 10) $display("mismatch exp %p got %p", e, out_data);
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (word_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_VECTOR_LENGTH) vec_len = v[13:0];
    else rec_div = v;
  endtask

  function automatic ncc_in_t mk(bit t, int lab, int el, int sv);
    ncc_in_t w;
    w.req_type = t;
    w.class_label = lab[2:0];
    w.element_index = el[12:0];
    w.sample_value = sv[15:0];
    return w;
  endfunction

  // Queue training for every class then a few test vectors, random content
  task automatic queue_session(int len, int nvec, int ntrain);
    int k, c, e;
    for (k = 0; k < ntrain; k++)
      for (c = 0; c < NCLS; c++)
        for (e = 0; e < len; e++)
          word_q.push_back(mk(0, c, e, $urandom_range(0, 65535)));
    for (k = 0; k < nvec; k++)
      for (e = 0; e < len; e++) begin
        if ($urandom_range(0, 19) == 0)
          word_q.push_back(mk($urandom_range(0, 1), $urandom_range(0, 7),
                              $urandom_range(0, 8191), $urandom_range(0, 65535)));
        if (!(e == 0 && $urandom_range(0, 29) == 0))
          word_q.push_back(mk(1, $urandom_range(0, 7), e, $urandom_range(0, 65535)));
      end
  endtask

  int ph;
  initial begin
    for (int i = 0; i < NCLS*MAXD; i++) class_sum[i] = '0;
    for (int i = 0; i < NCLS; i++) class_dist[i] = '0;
    want_label = '0;
    vec_len = 14'd1536;
    rec_div = 16'd200;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // Extremes on a 2-element vector: full-scale samples, zero divisor, bad class and index
    write_reg(REG_VECTOR_LENGTH, 16'd2);
    write_reg(REG_RECORDS_PER_CLASS, 16'd0);
    for (int i = 0; i < 3; i++) word_q.push_back(mk(0, 1, 0, 32767));
    word_q.push_back(mk(0, 2, 1, -32768));
    word_q.push_back(mk(0, 7, 0, 100));
    word_q.push_back(mk(0, 0, 5, 100));
    word_q.push_back(mk(1, 3, 0, -32768));
    word_q.push_back(mk(1, 3, 1, 32767));
    word_q.push_back(mk(1, 3, 1, 0));
    word_q.push_back(mk(1, 6, 0, 32767));
    word_q.push_back(mk(1, 6, 1, -32768));
    word_q.push_back(mk(1, 0, 1, 1));
    word_q.push_back(mk(1, 0, 8191, 1));
    wait_idle();
    // With every expectation met, hold traffic off over the register writes, then restart it
    hold_off = 1'b1;
    write_reg(REG_VECTOR_LENGTH, 16'd0);
    write_reg(REG_RECORDS_PER_CLASS, 16'd1);
    hold_off = 1'b0;
    queue_session(1, 30, 2);
    wait_idle();
    for (ph = 0; ph < 12; ph++) begin
      write_reg(REG_VECTOR_LENGTH, 16'($urandom_range(2, 6)));
      write_reg(REG_RECORDS_PER_CLASS, (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 4)));
      queue_session(int'(vec_len), 12, $urandom_range(1, 3));
      wait_idle();
    end
    // Largest length once, few elements touched
    write_reg(REG_VECTOR_LENGTH, 16'h3FFF);
    word_q.push_back(mk(0, 4, 8191, -5));
    word_q.push_back(mk(1, 4, 0, 9));
    word_q.push_back(mk(1, 4, 8191, 3));
    wait_idle();
    if (errors == 0) $display("[nearest_centroid_classify] OK");
    else $display("[nearest_centroid_classify] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000_000;
    $display("[nearest_centroid_classify] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/ncc_pkg.sv
rtl/core/ncc_cell.sv
rtl/core/nearest_centroid_classify.sv
verif/tb_nearest_centroid_classify.sv
